>>> hdl/crc32wp_pkg.sv
// crc32wp_pkg: shared types and constants for the word-packed crc-32 core
// holds the request struct and the fold table built at elaboration
// no dependencies
`default_nettype none

package crc32wp_pkg;

    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_TOP  = 32'h8000_0000;

    localparam int unsigned CRC_WIDTH    = 32;
    localparam int unsigned BYTE_WIDTH   = 8;
    localparam int unsigned GATHER_WIDTH = 24;
    localparam int unsigned SLOT_WIDTH   = 2;
    localparam logic [SLOT_WIDTH-1:0] SLOT_FULL = 2'd3;

    typedef struct packed {
        logic [BYTE_WIDTH-1:0] data_byte;
        logic                  last;
    } byte_req_t;

    typedef logic [CRC_WIDTH-1:0] fold_table_t [CRC_WIDTH];

    // response of 32 msb-first shift steps to each single set bit
    function automatic fold_table_t build_fold_table();
        fold_table_t tbl;
        logic [CRC_WIDTH-1:0] c;
        for (int i = 0; i < CRC_WIDTH; i++)
        begin
            c = CRC_WIDTH'(1) << i;
            for (int n = 0; n < CRC_WIDTH; n++)
            begin
                if ((c & CRC_TOP) != '0)
                begin
                    c = (c << 1) ^ CRC_POLY;
                end
                else
                begin
                    c = c << 1;
                end
            end
            tbl[i] = c;
        end
        return tbl;
    endfunction

    localparam fold_table_t FOLD_TABLE = build_fold_table();

endpackage

`default_nettype wire

>>> hdl/crc32_word_lsb_packed_core.sv
// crc32_word_lsb_packed_core: crc-32 (poly 04c11db7, msb first, init all ones,
// no reflection, no final xor) over bytes packed lsb-first into 32-bit words.
//
// input channel s_*: one message byte per request, s_tlast marks the final
// byte of a message. output channel m_*: one request per message carrying
// the finished crc, issued after the byte marked last.
// a short final word is zero padded in its upper bytes before folding.
//
// throughput: one byte per cycle sustained; the whole 32-step fold is a
// flat xor network between the input register and the crc/result registers.
// m_tvalid is registered: set as the last byte leaves the input register.
// when the receiver stalls, bytes keep flowing until a last byte meets a
// still-pending result; that byte then waits in the input register and
// s_tready drops until m_tready frees the result register.
// reset: crc state returns to all ones, byte lane and gathered bytes clear,
// both registers empty. after each last byte the crc restarts at all ones.
// depends on crc32wp_pkg, crc32wp_accum, crc32wp_fold
`default_nettype none

module crc32_word_lsb_packed_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata    // [31:0] crc_value
);

    logic                   stage_valid_reg;
    logic                   stage_valid_next;
    crc32wp_pkg::byte_req_t stage_req_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [31:0]            out_crc_reg;
    logic [31:0]            crc_done;
    logic                   commit;
    logic                   in_take;

    // a last byte may only move on if the result register is free
    assign commit = stage_valid_reg
                 && (!stage_req_reg.last || !out_valid_reg || m_tready);

    assign s_tready = !stage_valid_reg || commit;
    assign in_take  = s_tvalid && s_tready;

    crc32wp_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (commit),
        .req      (stage_req_reg),
        .crc_done (crc_done)
    );

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (in_take)
        begin
            stage_valid_next = 1'b1;
        end
        else if (commit)
        begin
            stage_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (commit && stage_req_reg.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            stage_req_reg.data_byte <= s_tdata;
            stage_req_reg.last      <= s_tlast;
        end
        if (commit && stage_req_reg.last)
        begin
            out_crc_reg <= crc_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_crc_reg;

    // a committed last byte always leaves a result behind
    a_last_gives_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (commit && stage_req_reg.last) |=> m_tvalid
    ) else $error("last byte committed without a result");

    // input only backs up behind a held last byte and a stalled result
    a_stall_cause: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> (stage_valid_reg && stage_req_reg.last && m_tvalid && !m_tready)
    ) else $error("input stalled without a pending result");

    // a taken result is not repeated unless a new message finished
    a_no_repeat: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !(commit && stage_req_reg.last)) |=> !m_tvalid
    ) else $error("result repeated after being taken");

endmodule

`default_nettype wire

>>> hdl/crc32wp_fold.sv
// crc32wp_fold: one full-word crc fold as a flat xor network
// uses crc32wp_pkg::FOLD_TABLE (the fold is linear, so columns are summed)
`default_nettype none

module crc32wp_fold (
    input  wire logic [31:0] crc_in,
    input  wire logic [31:0] word_in,
    output logic      [31:0] crc_out
);

    logic [31:0] mixed;

    assign mixed = crc_in ^ word_in;

    always_comb
    begin
        crc_out = '0;
        for (int i = 0; i < crc32wp_pkg::CRC_WIDTH; i++)
        begin
            if (mixed[i])
            begin
                crc_out = crc_out ^ crc32wp_pkg::FOLD_TABLE[i];
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/crc32wp_accum.sv
// crc32wp_accum: byte gathering into lsb-first words and running crc state
// depends on crc32wp_pkg and crc32wp_fold
`default_nettype none

module crc32wp_accum (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   commit,
    input  wire crc32wp_pkg::byte_req_t req,
    output logic [31:0]                 crc_done
);

    logic [23:0] gather_reg;
    logic [23:0] gather_next;
    logic [1:0]  slot_reg;
    logic [1:0]  slot_next;
    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] word;
    logic [31:0] folded;
    logic        fold_en;

    // new byte lands in lane slot, upper lanes stay zero for a short word
    assign word = {8'd0, gather_reg}
                | ({24'd0, req.data_byte} << {slot_reg, 3'b000});

    assign fold_en = (slot_reg == crc32wp_pkg::SLOT_FULL) || req.last;

    crc32wp_fold u_fold (
        .crc_in  (crc_reg),
        .word_in (word),
        .crc_out (folded)
    );

    assign crc_done = folded;

    always_comb
    begin
        gather_next = gather_reg;
        slot_next   = slot_reg;
        crc_next    = crc_reg;
        if (commit)
        begin
            if (fold_en)
            begin
                gather_next = '0;
                slot_next   = '0;
                crc_next    = req.last ? crc32wp_pkg::CRC_INIT : folded;
            end
            else
            begin
                gather_next = word[23:0];
                slot_next   = slot_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gather_reg <= '0;
            slot_reg   <= '0;
            crc_reg    <= crc32wp_pkg::CRC_INIT;
        end
        else
        begin
            gather_reg <= gather_next;
            slot_reg   <= slot_next;
            crc_reg    <= crc_next;
        end
    end

endmodule

`default_nettype wire
